### rtl/lf_pkg.sv
`timescale 1ns / 1ps

package lf_pkg;

  parameter int LEVEL_W    = 7;
  parameter int TICKS_W    = 16;
  parameter int TIMEOUT_W  = 32;
  parameter int CFG_IDX_W  = 3;
  parameter int CFG_DATA_W = 32;
  parameter int ACT_W      = 2;

  parameter int LEVEL_MAX_DEF = 100;

  localparam logic [TICKS_W-1:0]   START_TICKS_RST  = 16'd300;
  localparam logic [TICKS_W-1:0]   NORMAL_TICKS_RST = 16'd100;
  localparam logic [TICKS_W-1:0]   OFF_TICKS_RST    = 16'd5000;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST      = 32'd2700000;
  localparam logic [LEVEL_W-1:0]   MIN_LEVEL_RST    = 7'd0;
  localparam logic [LEVEL_W-1:0]   DEFAULT_LEVEL_RST = 7'd50;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_START_TICKS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_TICKS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_TICKS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_LEVEL = 3'd5;

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK     = 2'd0,
    ACT_SET      = 2'd1,
    ACT_ACTIVITY = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    MODE_STARTING = 2'd0,
    MODE_NORMAL   = 2'd1,
    MODE_STANDBY  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_FIN
  } ctrl_state_t;

  typedef enum logic [1:0] {
    EV_NONE,
    EV_EMIT,
    EV_DIVIDE
  } eval_kind_t;

  typedef struct packed {
    logic accept;
    logic commit;
    logic div_start;
    logic finish;
  } lf_cmd_t;

  typedef struct packed {
    eval_kind_t kind;
    logic       slot_free;
    logic       div_done;
  } lf_status_t;

endpackage

### rtl/led_level_fader.sv
`timescale 1ns / 1ps
// Linear LED brightness fader.
// Input requests (in_valid/in_ready): in_action 0 = timer tick, 1 = new target
// (in_target_level), 2 = user activity. Each request gives zero or one result
// on out_valid/out_ready: the level just applied and whether the fade goes on.
// Config port: cfg_we writes cfg_data into register cfg_index at once; write
// only while the block is idle.
// One request at a time. A request that starts a fade with a nonzero step
// count goes through an evaluation step, a bit-serial divide of the fade
// ticks by the step count, the divider's done strobe and a finish step that
// gives its result; the next request is taken after the finish step. Any
// other request gives its result, if any, from its evaluation step, and the
// next request is taken once the block is back in idle.
// The result sits in an output register; the next request is accepted while
// it waits. If the receiver stalls, a request that needs to emit waits at
// its evaluation or finish step until the register frees up.
// Reset (rst_n low, synchronous): config returns to its defaults, level is
// the minimum level, the goal the default level, and the first tick starts
// the power-up fade.
module led_level_fader #(
  parameter int LEVEL_MAX = lf_pkg::LEVEL_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [lf_pkg::ACT_W-1:0]       in_action,
  input  logic [lf_pkg::LEVEL_W-1:0]     in_target_level,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [lf_pkg::LEVEL_W-1:0]     out_level,
  output logic                           out_fading,
  input  logic                           cfg_we,
  input  logic [lf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  lf_pkg::lf_cmd_t    cmd;
  lf_pkg::lf_status_t status;

  lf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  lf_dp #(
    .LEVEL_MAX (LEVEL_MAX)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_action       (in_action),
    .in_target_level (in_target_level),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_level       (out_level),
    .out_fading      (out_fading)
  );

endmodule

### rtl/lf_div.sv
`timescale 1ns / 1ps

module lf_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [lf_pkg::TICKS_W-1:0]  dividend,
  input  logic [lf_pkg::LEVEL_W-1:0]  divisor,
  output logic [lf_pkg::TICKS_W-1:0]  quotient,
  output logic                        done
);

  localparam int CNT_W = $clog2(lf_pkg::TICKS_W);

  logic [lf_pkg::TICKS_W-1:0] work_r, work_nxt;
  logic [lf_pkg::LEVEL_W-1:0] rem_r, rem_nxt;
  logic [lf_pkg::LEVEL_W-1:0] div_r, div_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [lf_pkg::LEVEL_W:0]   shifted;
  logic [lf_pkg::LEVEL_W:0]   diff;
  logic                       ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    shifted  = {rem_r, work_r[lf_pkg::TICKS_W-1]};
    diff     = shifted - {1'b0, div_r};
    ge       = shifted >= {1'b0, div_r};
    work_nxt = work_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      work_nxt = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      work_nxt = {work_r[lf_pkg::TICKS_W-2:0], ge};
      rem_nxt  = ge ? diff[lf_pkg::LEVEL_W-1:0] : shifted[lf_pkg::LEVEL_W-1:0];
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(lf_pkg::TICKS_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    cnt_r  <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quotient = work_r;
  assign done     = done_r;

endmodule

### rtl/lf_dp.sv
`timescale 1ns / 1ps

module lf_dp #(
  parameter int LEVEL_MAX = lf_pkg::LEVEL_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lf_pkg::lf_cmd_t                cmd,
  output lf_pkg::lf_status_t             status,
  input  logic [lf_pkg::ACT_W-1:0]       in_action,
  input  logic [lf_pkg::LEVEL_W-1:0]     in_target_level,
  input  logic                           cfg_we,
  input  logic [lf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lf_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [lf_pkg::LEVEL_W-1:0]     out_level,
  output logic                           out_fading
);

  localparam logic [lf_pkg::LEVEL_W-1:0] LVL_MAX = lf_pkg::LEVEL_W'(LEVEL_MAX);

  function automatic logic [lf_pkg::LEVEL_W-1:0] sat_level(
    input logic [lf_pkg::LEVEL_W-1:0] v
  );
    return (v > LVL_MAX) ? LVL_MAX : v;
  endfunction

  function automatic logic [lf_pkg::LEVEL_W-1:0] step_toward(
    input logic [lf_pkg::LEVEL_W-1:0] lvl,
    input logic [lf_pkg::LEVEL_W-1:0] goal
  );
    if (lvl < goal) return lvl + 1'b1;
    else if (lvl > goal) return lvl - 1'b1;
    else return lvl;
  endfunction

  // config
  logic [lf_pkg::TICKS_W-1:0]   start_ticks_r, start_ticks_nxt;
  logic [lf_pkg::TICKS_W-1:0]   normal_ticks_r, normal_ticks_nxt;
  logic [lf_pkg::TICKS_W-1:0]   off_ticks_r, off_ticks_nxt;
  logic [lf_pkg::TIMEOUT_W-1:0] timeout_r, timeout_nxt;
  logic [lf_pkg::LEVEL_W-1:0]   min_level_r, min_level_nxt;

  // fade state
  logic [lf_pkg::LEVEL_W-1:0]   level_now_r, level_now_nxt;
  logic [lf_pkg::LEVEL_W-1:0]   level_goal_r, level_goal_nxt;
  lf_pkg::mode_t                mode_r, mode_nxt;
  logic [lf_pkg::LEVEL_W-1:0]   steps_left_r, steps_left_nxt;
  logic [lf_pkg::TICKS_W-1:0]   step_period_r, step_period_nxt;
  logic [lf_pkg::TICKS_W-1:0]   period_count_r, period_count_nxt;
  logic                         restart_pending_r, restart_pending_nxt;
  logic                         idle_running_r, idle_running_nxt;
  logic [lf_pkg::TIMEOUT_W-1:0] idle_count_r, idle_count_nxt;

  // request and result registers
  logic [lf_pkg::ACT_W-1:0]     act_r, act_nxt;
  logic [lf_pkg::LEVEL_W-1:0]   target_r, target_nxt;
  logic [lf_pkg::LEVEL_W-1:0]   n_r, n_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [lf_pkg::LEVEL_W-1:0]   out_level_r, out_level_nxt;
  logic                         out_fading_r, out_fading_nxt;

  // evaluation of the held request
  logic [lf_pkg::LEVEL_W-1:0]   goal_pre;
  lf_pkg::mode_t                mode_pre;
  logic                         is_start;
  logic                         step_now;
  logic                         idle_run_e;
  logic [lf_pkg::TIMEOUT_W-1:0] idle_cnt_e;
  logic [lf_pkg::TIMEOUT_W-1:0] idle_inc;
  logic [lf_pkg::TICKS_W-1:0]   pc_e;
  logic [lf_pkg::TICKS_W-1:0]   pc_inc;
  logic [lf_pkg::LEVEL_W-1:0]   span;
  logic [lf_pkg::TICKS_W-1:0]   ticks_sel;
  lf_pkg::eval_kind_t           kind;
  logic [lf_pkg::LEVEL_W-1:0]   level_step;
  logic [lf_pkg::LEVEL_W-1:0]   steps_dec;
  logic [lf_pkg::LEVEL_W-1:0]   n_dec;
  logic [lf_pkg::LEVEL_W-1:0]   level_fin;
  logic [lf_pkg::TICKS_W-1:0]   quotient;
  logic                         div_done;
  logic                         slot_free;
  logic                         load_out;

  always_comb begin
    goal_pre   = level_goal_r;
    mode_pre   = mode_r;
    is_start   = 1'b0;
    step_now   = 1'b0;
    idle_run_e = idle_running_r;
    idle_cnt_e = idle_count_r;
    idle_inc   = idle_count_r + 1'b1;
    pc_inc     = period_count_r + 1'b1;
    pc_e       = period_count_r;
    case (act_r)
      lf_pkg::ACT_SET: begin
        mode_pre = (steps_left_r != '0) ? lf_pkg::MODE_NORMAL : mode_r;
        goal_pre = target_r;
        is_start = 1'b1;
      end
      lf_pkg::ACT_ACTIVITY: begin
        idle_run_e = 1'b1;
        idle_cnt_e = '0;
        mode_pre   = lf_pkg::MODE_NORMAL;
      end
      lf_pkg::ACT_TICK: begin
        if (idle_running_r) begin
          idle_cnt_e = idle_inc;
        end
        if (idle_running_r && (idle_inc >= timeout_r)) begin
          idle_run_e = 1'b0;
          goal_pre   = sat_level(min_level_r);
          mode_pre   = lf_pkg::MODE_STANDBY;
          is_start   = 1'b1;
        end else if (restart_pending_r) begin
          is_start = 1'b1;
        end else if (steps_left_r != '0) begin
          if (pc_inc >= step_period_r) begin
            pc_e     = '0;
            step_now = 1'b1;
          end else begin
            pc_e = pc_inc;
          end
        end
      end
      default: ;
    endcase

    span = (level_now_r > goal_pre) ? (level_now_r - goal_pre) : (goal_pre - level_now_r);

    case (mode_pre)
      lf_pkg::MODE_STARTING: ticks_sel = start_ticks_r;
      lf_pkg::MODE_STANDBY:  ticks_sel = off_ticks_r;
      default:               ticks_sel = normal_ticks_r;
    endcase

    if (is_start) begin
      kind = (span == '0) ? lf_pkg::EV_EMIT : lf_pkg::EV_DIVIDE;
    end else if (step_now) begin
      kind = lf_pkg::EV_EMIT;
    end else begin
      kind = lf_pkg::EV_NONE;
    end

    level_step = step_toward(level_now_r, level_goal_r);
    steps_dec  = steps_left_r - 1'b1;
    n_dec      = n_r - 1'b1;
    level_fin  = step_toward(level_now_r, level_goal_r);
  end

  lf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (ticks_sel),
    .divisor  (span),
    .quotient (quotient),
    .done     (div_done)
  );

  assign slot_free = !out_valid_r || out_ready;
  assign load_out  = (cmd.commit && (kind == lf_pkg::EV_EMIT)) || cmd.finish;

  always_comb begin
    start_ticks_nxt     = start_ticks_r;
    normal_ticks_nxt    = normal_ticks_r;
    off_ticks_nxt       = off_ticks_r;
    timeout_nxt         = timeout_r;
    min_level_nxt       = min_level_r;
    level_now_nxt       = level_now_r;
    level_goal_nxt      = level_goal_r;
    mode_nxt            = mode_r;
    steps_left_nxt      = steps_left_r;
    step_period_nxt     = step_period_r;
    period_count_nxt    = period_count_r;
    restart_pending_nxt = restart_pending_r;
    idle_running_nxt    = idle_running_r;
    idle_count_nxt      = idle_count_r;
    act_nxt             = act_r;
    target_nxt          = target_r;
    n_nxt               = n_r;
    out_level_nxt       = out_level_r;
    out_fading_nxt      = out_fading_r;
    out_valid_nxt       = out_valid_r && !out_ready;

    // default_level only sets the goal at reset, so a write has no effect
    if (cfg_we) begin
      case (cfg_index)
        lf_pkg::CFG_START_TICKS:  start_ticks_nxt  = cfg_data[lf_pkg::TICKS_W-1:0];
        lf_pkg::CFG_NORMAL_TICKS: normal_ticks_nxt = cfg_data[lf_pkg::TICKS_W-1:0];
        lf_pkg::CFG_OFF_TICKS:    off_ticks_nxt    = cfg_data[lf_pkg::TICKS_W-1:0];
        lf_pkg::CFG_IDLE_TIMEOUT: timeout_nxt      = cfg_data[lf_pkg::TIMEOUT_W-1:0];
        lf_pkg::CFG_MIN_LEVEL:    min_level_nxt    = cfg_data[lf_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end

    if (cmd.accept) begin
      act_nxt    = in_action;
      target_nxt = sat_level(in_target_level);
    end

    if (cmd.commit) begin
      level_goal_nxt   = goal_pre;
      mode_nxt         = mode_pre;
      idle_running_nxt = idle_run_e;
      idle_count_nxt   = idle_cnt_e;
      period_count_nxt = pc_e;
      if (is_start) begin
        restart_pending_nxt = 1'b0;
        period_count_nxt    = '0;
        n_nxt               = span;
        if (span == '0) begin
          steps_left_nxt = '0;
          mode_nxt       = lf_pkg::MODE_NORMAL;
          out_level_nxt  = level_now_r;
          out_fading_nxt = 1'b0;
        end
      end else if (step_now) begin
        level_now_nxt  = level_step;
        steps_left_nxt = steps_dec;
        if (steps_dec == '0) begin
          mode_nxt = lf_pkg::MODE_NORMAL;
        end
        out_level_nxt  = level_step;
        out_fading_nxt = (steps_dec != '0);
      end
    end

    // first step of a fade, once the step period is known
    if (cmd.finish) begin
      step_period_nxt = (quotient == '0) ? lf_pkg::TICKS_W'(1) : quotient;
      steps_left_nxt  = n_dec;
      level_now_nxt   = level_fin;
      if (n_dec == '0) begin
        mode_nxt = lf_pkg::MODE_NORMAL;
      end
      out_level_nxt  = level_fin;
      out_fading_nxt = (n_dec != '0);
    end

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    act_r          <= act_nxt;
    target_r       <= target_nxt;
    n_r            <= n_nxt;
    out_level_r    <= out_level_nxt;
    out_fading_r   <= out_fading_nxt;
    if (!rst_n) begin
      start_ticks_r     <= lf_pkg::START_TICKS_RST;
      normal_ticks_r    <= lf_pkg::NORMAL_TICKS_RST;
      off_ticks_r       <= lf_pkg::OFF_TICKS_RST;
      timeout_r         <= lf_pkg::TIMEOUT_RST;
      min_level_r       <= lf_pkg::MIN_LEVEL_RST;
      level_now_r       <= sat_level(lf_pkg::MIN_LEVEL_RST);
      level_goal_r      <= sat_level(lf_pkg::DEFAULT_LEVEL_RST);
      mode_r            <= lf_pkg::MODE_STARTING;
      steps_left_r      <= '0;
      step_period_r     <= lf_pkg::TICKS_W'(1);
      period_count_r    <= '0;
      restart_pending_r <= 1'b1;
      idle_running_r    <= 1'b0;
      idle_count_r      <= '0;
      out_valid_r       <= 1'b0;
    end else begin
      start_ticks_r     <= start_ticks_nxt;
      normal_ticks_r    <= normal_ticks_nxt;
      off_ticks_r       <= off_ticks_nxt;
      timeout_r         <= timeout_nxt;
      min_level_r       <= min_level_nxt;
      level_now_r       <= level_now_nxt;
      level_goal_r      <= level_goal_nxt;
      mode_r            <= mode_nxt;
      steps_left_r      <= steps_left_nxt;
      step_period_r     <= step_period_nxt;
      period_count_r    <= period_count_nxt;
      restart_pending_r <= restart_pending_nxt;
      idle_running_r    <= idle_running_nxt;
      idle_count_r      <= idle_count_nxt;
      out_valid_r       <= out_valid_nxt;
    end
  end

  always_comb begin
    status.kind      = kind;
    status.slot_free = slot_free;
    status.div_done  = div_done;
  end

  assign out_valid  = out_valid_r;
  assign out_level  = out_level_r;
  assign out_fading = out_fading_r;

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    (level_now_r <= LVL_MAX) && (level_goal_r <= LVL_MAX))
    else $error("level outside range");

  a_period_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    step_period_r != '0)
    else $error("step period is zero");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    period_count_r <= step_period_r)
    else $error("period count passed step period");

endmodule

### rtl/lf_ctrl.sv
`timescale 1ns / 1ps

module lf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lf_pkg::lf_status_t status,
  output lf_pkg::lf_cmd_t    cmd
);

  lf_pkg::ctrl_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lf_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = lf_pkg::ST_EVAL;
      end
      lf_pkg::ST_EVAL: begin
        case (status.kind)
          lf_pkg::EV_DIVIDE: state_nxt = lf_pkg::ST_DIV;
          lf_pkg::EV_EMIT: begin
            if (status.slot_free) state_nxt = lf_pkg::ST_IDLE;
          end
          default: state_nxt = lf_pkg::ST_IDLE;
        endcase
      end
      lf_pkg::ST_DIV: begin
        if (status.div_done) state_nxt = lf_pkg::ST_FIN;
      end
      lf_pkg::ST_FIN: begin
        if (status.slot_free) state_nxt = lf_pkg::ST_IDLE;
      end
      default: state_nxt = lf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.accept    = 1'b0;
    cmd.commit    = 1'b0;
    cmd.div_start = 1'b0;
    cmd.finish    = 1'b0;
    case (state_r)
      lf_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      lf_pkg::ST_EVAL: begin
        case (status.kind)
          lf_pkg::EV_DIVIDE: begin
            cmd.commit    = 1'b1;
            cmd.div_start = 1'b1;
          end
          lf_pkg::EV_EMIT: cmd.commit = status.slot_free;
          default:         cmd.commit = 1'b1;
        endcase
      end
      lf_pkg::ST_FIN: cmd.finish = status.slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_div_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lf_pkg::ST_DIV) && status.div_done |=> state_r == lf_pkg::ST_FIN)
    else $error("division done but no finish");

  a_eval_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lf_pkg::ST_EVAL) && (status.kind == lf_pkg::EV_DIVIDE)
      |=> state_r == lf_pkg::ST_DIV)
    else $error("fade start did not enter division");

  a_fin_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lf_pkg::ST_FIN) && status.slot_free |=> state_r == lf_pkg::ST_IDLE)
    else $error("finish step did not return to idle");

endmodule
